@@ src/vector_matrix_multiply_top_defines.svh @@
// assertion helpers shared by vmm_ctrl and vmm_dp
`ifndef VECTOR_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define VECTOR_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// clocked check, off while reset is held
`define VMM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition that must never be seen
`define VMM_NEVER(lbl, expr, msg) \
    `VMM_ASSERT(lbl, !(expr), msg)

`endif

@@ src/vmm_pkg.sv @@
`timescale 1ns / 1ps

package vmm_pkg;

    localparam int DEF_MAX_ROWS = 16;
    localparam int DEF_MAX_COLS = 16;

    localparam int CNT_W   = 5;
    localparam int IDX_W   = 4;
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 32;
    localparam int SUM_W   = 40;
    localparam int CMD_W   = 2;
    localparam int REG_W   = 2;

    localparam logic [CMD_W-1:0] CMD_LOAD_VEC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD_MAT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START    = 2'd2;

    localparam logic [REG_W-1:0] REG_VECTOR_LENGTH = 2'd0;
    localparam logic [REG_W-1:0] REG_ROW_COUNT     = 2'd1;
    localparam logic [REG_W-1:0] REG_COL_COUNT     = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_COL_WAIT,
        ST_RUN,
        ST_DRAIN,
        ST_ERR
    } vmm_state_t;

    typedef struct packed {
        logic vec_we;
        logic mat_we;
        logic issue;
        logic first;
        logic final_row;
        logic last_col;
        logic push;
        logic push_err;
    } vmm_cmd_t;

    typedef struct packed {
        logic out_busy;
        logic col_done;
    } vmm_status_t;

endpackage

@@ src/vmm_ram.sv @@
`timescale 1ns / 1ps

module vmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/vmm_ctrl.sv @@
`timescale 1ns / 1ps
`include "vector_matrix_multiply_top_defines.svh"

module vmm_ctrl import vmm_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [CMD_W-1:0] in_cmd,
    input  logic [IDX_W-1:0] in_row,
    input  logic [IDX_W-1:0] in_col,
    input  logic             cfg_valid,
    input  logic [REG_W-1:0] cfg_index,
    input  logic [CNT_W-1:0] cfg_data,
    input  vmm_status_t      stat,
    output vmm_cmd_t         cmd,
    output logic [RW-1:0]    row_sel,
    output logic [CW-1:0]    col_sel
);

    vmm_state_t       state_reg, state_next;
    logic [CNT_W-1:0] vec_len_reg, row_cnt_reg, col_cnt_reg;
    logic [RW-1:0]    row_last_reg, row_last_next;
    logic [CW-1:0]    col_last_reg, col_last_next;
    logic             rows_zero_reg, rows_zero_next;
    logic [RW-1:0]    i_reg, i_next;
    logic [CW-1:0]    j_reg, j_next;
    logic             size_bad;
    logic             row_ok, col_ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vec_len_reg <= '0;
            row_cnt_reg <= CNT_W'(1);
            col_cnt_reg <= CNT_W'(1);
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_VECTOR_LENGTH: vec_len_reg <= cfg_data;
                REG_ROW_COUNT:     row_cnt_reg <= cfg_data;
                REG_COL_COUNT:     col_cnt_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            row_last_reg  <= '0;
            col_last_reg  <= '0;
            rows_zero_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
        end else begin
            state_reg     <= state_next;
            row_last_reg  <= row_last_next;
            col_last_reg  <= col_last_next;
            rows_zero_reg <= rows_zero_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
        end
    end

    assign size_bad = (vec_len_reg != row_cnt_reg) || (col_cnt_reg == '0);
    assign row_ok   = (32'(in_row) < MAX_ROWS);
    assign col_ok   = (32'(in_col) < MAX_COLS);

    always_comb begin
        state_next     = state_reg;
        row_last_next  = row_last_reg;
        col_last_next  = col_last_reg;
        rows_zero_next = rows_zero_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        cmd            = '0;
        s_tready       = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    unique case (in_cmd)
                        CMD_LOAD_VEC: cmd.vec_we = row_ok;
                        CMD_LOAD_MAT: cmd.mat_we = row_ok && col_ok;
                        CMD_START: begin
                            i_next = '0;
                            j_next = '0;
                            if (size_bad) begin
                                state_next = ST_ERR;
                            end else begin
                                // counts above the store size saturate
                                rows_zero_next = (row_cnt_reg == '0);
                                row_last_next  = (32'(row_cnt_reg) > MAX_ROWS) ?
                                                 RW'(MAX_ROWS - 1) :
                                                 RW'(row_cnt_reg - CNT_W'(1));
                                col_last_next  = (32'(col_cnt_reg) > MAX_COLS) ?
                                                 CW'(MAX_COLS - 1) :
                                                 CW'(col_cnt_reg - CNT_W'(1));
                                state_next     = ST_COL_WAIT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_COL_WAIT: begin
                if (!stat.out_busy) begin
                    if (rows_zero_reg) begin
                        // empty sum, result goes out straight away
                        cmd.push     = 1'b1;
                        cmd.last_col = (j_reg == col_last_reg);
                        if (j_reg == col_last_reg) begin
                            state_next = ST_IDLE;
                        end else begin
                            j_next = j_reg + 1'b1;
                        end
                    end else begin
                        i_next     = '0;
                        state_next = ST_RUN;
                    end
                end
            end
            ST_RUN: begin
                cmd.issue     = 1'b1;
                cmd.first     = (i_reg == '0);
                cmd.final_row = (i_reg == row_last_reg);
                cmd.last_col  = (j_reg == col_last_reg);
                if (i_reg == row_last_reg) begin
                    state_next = ST_DRAIN;
                end else begin
                    i_next = i_reg + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (stat.col_done) begin
                    if (j_reg == col_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        j_next     = j_reg + 1'b1;
                        state_next = ST_COL_WAIT;
                    end
                end
            end
            ST_ERR: begin
                if (!stat.out_busy) begin
                    cmd.push     = 1'b1;
                    cmd.push_err = 1'b1;
                    cmd.last_col = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign row_sel = i_reg;
    assign col_sel = j_reg;

    `VMM_NEVER(a_run_out_empty, state_reg == ST_RUN && stat.out_busy, "output busy during run")
    `VMM_ASSERT(a_done_in_drain, stat.col_done |-> state_reg == ST_DRAIN, "column done outside drain")
    `VMM_ASSERT(a_err_col_zero, state_reg == ST_ERR |-> j_reg == '0, "error result column not zero")

endmodule

@@ src/vmm_dp.sv @@
`timescale 1ns / 1ps
`include "vector_matrix_multiply_top_defines.svh"

module vmm_dp import vmm_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS,
    parameter int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
    parameter int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  vmm_cmd_t                 cmd,
    input  logic [RW-1:0]            row_sel,
    input  logic [CW-1:0]            col_sel,
    input  logic [IDX_W-1:0]         wr_row,
    input  logic [IDX_W-1:0]         wr_col,
    input  logic signed [ELEM_W-1:0] wr_value,
    output vmm_status_t              stat,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic signed [SUM_W-1:0]  m_sum,
    output logic [IDX_W-1:0]         m_col,
    output logic                     m_last,
    output logic                     m_err
);

    localparam int MAT_DEPTH = MAX_ROWS * (1 << CW);

    logic signed [ELEM_W-1:0] vec_q, mat_q;

    logic                     s1_valid_reg, s1_first_reg, s1_final_reg, s1_lastc_reg;
    logic [CW-1:0]            s1_col_reg;
    logic                     s2_valid_reg, s2_first_reg, s2_final_reg, s2_lastc_reg;
    logic [CW-1:0]            s2_col_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg, acc_next;

    logic                     m_valid_reg;
    logic signed [SUM_W-1:0]  m_sum_reg;
    logic [IDX_W-1:0]         m_col_reg;
    logic                     m_last_reg, m_err_reg;

    vmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAX_ROWS),
        .ADDR_W(RW)
    ) u_vec_ram (
        .aclk   (aclk),
        .wr_en  (cmd.vec_we),
        .wr_addr(RW'(wr_row)),
        .wr_data(wr_value),
        .rd_addr(row_sel),
        .rd_data(vec_q)
    );

    // matrix word address is row and column side by side
    vmm_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (MAT_DEPTH),
        .ADDR_W(RW + CW)
    ) u_mat_ram (
        .aclk   (aclk),
        .wr_en  (cmd.mat_we),
        .wr_addr({RW'(wr_row), CW'(wr_col)}),
        .wr_data(wr_value),
        .rd_addr({row_sel, col_sel}),
        .rd_data(mat_q)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        s1_first_reg <= cmd.first;
        s1_final_reg <= cmd.final_row;
        s1_lastc_reg <= cmd.last_col;
        s1_col_reg   <= col_sel;
        s2_first_reg <= s1_first_reg;
        s2_final_reg <= s1_final_reg;
        s2_lastc_reg <= s1_lastc_reg;
        s2_col_reg   <= s1_col_reg;
        prod_reg     <= vec_q * mat_q;
        if (s2_valid_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign acc_next = s2_first_reg ? SUM_W'(prod_reg) : acc_reg + SUM_W'(prod_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s2_valid_reg && s2_final_reg) begin
            m_valid_reg <= 1'b1;
        end else if (cmd.push) begin
            m_valid_reg <= 1'b1;
        end else if (m_valid_reg && m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_valid_reg && s2_final_reg) begin
            m_sum_reg  <= acc_next;
            m_col_reg  <= IDX_W'(s2_col_reg);
            m_last_reg <= s2_lastc_reg;
            m_err_reg  <= 1'b0;
        end else if (cmd.push) begin
            m_sum_reg  <= '0;
            m_col_reg  <= IDX_W'(col_sel);
            m_last_reg <= cmd.last_col;
            m_err_reg  <= cmd.push_err;
        end
    end

    assign stat.out_busy = m_valid_reg;
    assign stat.col_done = s2_valid_reg && s2_final_reg;

    assign m_tvalid = m_valid_reg;
    assign m_sum    = m_sum_reg;
    assign m_col    = m_col_reg;
    assign m_last   = m_last_reg;
    assign m_err    = m_err_reg;

    `VMM_NEVER(a_load_on_busy, s2_valid_reg && s2_final_reg && m_valid_reg, "result over a waiting word")
    `VMM_NEVER(a_push_in_flight, cmd.push && (s1_valid_reg || s2_valid_reg), "push while column in flight")
    `VMM_ASSERT(a_err_is_last, m_tvalid && m_err |-> m_last && m_sum == '0, "error word malformed")

endmodule

@@ src/vector_matrix_multiply_top.sv @@
`timescale 1ns / 1ps
// load words: one per cycle while idle, no result; start: one result word per column
// (rows issued back to back from the two ram read ports, then multiply and accumulate stages)
// a column only begins once the previous result word is taken, so an output stall delays it
// size error: one result, pushed from the error state once the output is free
// aresetn is synchronous, active low; it clears control and config, not the stores

module vector_matrix_multiply_top import vmm_pkg::*; #(
    parameter int MAX_ROWS = DEF_MAX_ROWS,
    parameter int MAX_COLS = DEF_MAX_COLS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [23:0]      s_tdata,   // row_index[3:0], col_index[7:4], element_value[23:8]
    input  logic [1:0]       s_tuser,   // cmd[1:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // product_sum[39:0], out_column[43:40], zero pad
    output logic [0:0]       m_tuser,   // size_error[0]
    output logic             m_tlast,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [REG_W-1:0] cfg_index,
    input  logic [CNT_W-1:0] cfg_data
);

    localparam int RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

    vmm_cmd_t                cmd;
    vmm_status_t             stat;
    logic [RW-1:0]           row_sel;
    logic [CW-1:0]           col_sel;
    logic signed [SUM_W-1:0] m_sum;
    logic [IDX_W-1:0]        m_col;
    logic                    m_last, m_err;

    assign cfg_ready = 1'b1;

    vmm_ctrl #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS),
        .RW      (RW),
        .CW      (CW)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .in_cmd   (s_tuser),
        .in_row   (s_tdata[3:0]),
        .in_col   (s_tdata[7:4]),
        .cfg_valid(cfg_valid),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .stat     (stat),
        .cmd      (cmd),
        .row_sel  (row_sel),
        .col_sel  (col_sel)
    );

    vmm_dp #(
        .MAX_ROWS(MAX_ROWS),
        .MAX_COLS(MAX_COLS),
        .RW      (RW),
        .CW      (CW)
    ) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .row_sel (row_sel),
        .col_sel (col_sel),
        .wr_row  (s_tdata[3:0]),
        .wr_col  (s_tdata[7:4]),
        .wr_value(s_tdata[23:8]),
        .stat    (stat),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_sum   (m_sum),
        .m_col   (m_col),
        .m_last  (m_last),
        .m_err   (m_err)
    );

    assign m_tdata = {4'b0000, m_col, m_sum};
    assign m_tuser = m_err;
    assign m_tlast = m_last;

endmodule

@@ bench/vector_matrix_multiply_top_test.sv @@
`timescale 1ns / 1ps

module vector_matrix_multiply_top_test;
    import vmm_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [REG_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int TARGET_WORDS  = 470;
    localparam int MAX_REPORTS   = 200;

    typedef struct {
        logic signed [SUM_W-1:0] sum;
        logic [IDX_W-1:0]        column;
        logic                    last;
        logic                    size_error;
    } column_result_t;

    // mirrors both stores and the size registers, queues the column sums each start owes
    class column_sum_board;
        logic signed [ELEM_W-1:0] vec_mem [DEF_MAX_ROWS];
        logic signed [ELEM_W-1:0] mat_mem [DEF_MAX_ROWS][DEF_MAX_COLS];
        logic [CNT_W-1:0] vector_length;
        logic [CNT_W-1:0] row_count;
        logic [CNT_W-1:0] col_count;
        column_result_t   expected_sums [$];
        int mismatches;
        int results_seen;
        int error_results;

        function new();
            foreach (vec_mem[i]) vec_mem[i] = '0;
            foreach (mat_mem[i, j]) mat_mem[i][j] = '0;
            vector_length = 5'd0;
            row_count     = 5'd1;
            col_count     = 5'd1;
            mismatches    = 0;
            results_seen  = 0;
            error_results = 0;
        endfunction

        function void set_register(input logic [REG_W-1:0] idx,
                                   input logic [CNT_W-1:0] data);
            case (idx)
                REG_VECTOR_LENGTH: vector_length = data;
                REG_ROW_COUNT:     row_count = data;
                REG_COL_COUNT:     col_count = data;
                default: ;
            endcase
        endfunction

        function void note_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                                input logic [IDX_W-1:0] col,
                                input logic signed [ELEM_W-1:0] value);
            int rows;
            int cols;
            longint acc;
            column_result_t res;
            case (cmd)
                CMD_LOAD_VEC: vec_mem[row] = value;
                CMD_LOAD_MAT: mat_mem[row][col] = value;
                CMD_START: begin
                    if (vector_length != row_count || col_count == 0) begin
                        res.sum        = '0;
                        res.column     = '0;
                        res.last       = 1'b1;
                        res.size_error = 1'b1;
                        expected_sums.push_back(res);
                    end else begin
                        rows = (row_count > DEF_MAX_ROWS) ? DEF_MAX_ROWS : row_count;
                        cols = (col_count > DEF_MAX_COLS) ? DEF_MAX_COLS : col_count;
                        for (int c = 0; c < cols; c++) begin
                            acc = 0;
                            for (int r = 0; r < rows; r++)
                                acc += longint'(vec_mem[r]) * longint'(mat_mem[r][c]);
                            res.sum        = acc[SUM_W-1:0];
                            res.column     = c[IDX_W-1:0];
                            res.last       = (c == cols - 1);
                            res.size_error = 1'b0;
                            expected_sums.push_back(res);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void report(input string field, input longint got, input longint want);
            if (mismatches < MAX_REPORTS)
                $display("mismatch %s on result word %0d: got %0d, want %0d",
                         field, results_seen, got, want);
            mismatches++;
        endfunction

        function void check_word(input logic signed [SUM_W-1:0] sum,
                                 input logic [IDX_W-1:0] column,
                                 input logic last, input logic size_error);
            column_result_t want;
            results_seen++;
            if (expected_sums.size() == 0) begin
                report("unrequested word", sum, 0);
                return;
            end
            want = expected_sums.pop_front();
            if (want.size_error)
                error_results++;
            if (sum !== want.sum)
                report("product_sum", sum, want.sum);
            if (column !== want.column)
                report("out_column", column, want.column);
            if (last !== want.last)
                report("last", last, want.last);
            if (size_error !== want.size_error)
                report("size_error", size_error, want.size_error);
        endfunction
    endclass

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [23:0]      s_tdata = '0;
    logic [1:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [47:0]      m_tdata;
    logic [0:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [REG_W-1:0] cfg_index = '0;
    logic [CNT_W-1:0] cfg_data = '0;

    column_sum_board board = new();

    bit vec_loaded [DEF_MAX_ROWS];
    bit mat_loaded [DEF_MAX_ROWS][DEF_MAX_COLS];
    int words_sent = 0;
    int loads_sent = 0;
    int starts_sent = 0;
    int cfg_writes = 0;
    int cycle_count = 0;
    bit calm = 1'b0;

    always #1 aclk = ~aclk;

    vector_matrix_multiply_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d result words outstanding", board.expected_sums.size());
            $display("[vector_matrix_multiply_top] ERROR");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            board.check_word($signed(m_tdata[39:0]), m_tdata[43:40], m_tlast, m_tuser[0]);
    end

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (calm || roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [ELEM_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 15)
            return 16'sh8000;
        if (roll < 30)
            return 16'sh7FFF;
        if (roll < 38)
            return 16'sh0000;
        if (roll < 44)
            return 16'shFFFF;
        return ELEM_W'($urandom_range(0, 65535));
    endfunction

    // result side: ready in bursts, broken by stalls
    initial begin
        int stall;
        forever begin
            @(posedge aclk);
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            stall = pick_gap();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] row,
                             input logic [IDX_W-1:0] col,
                             input logic signed [ELEM_W-1:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {value, col, row};
        do @(posedge aclk); while (!s_tready);
        board.note_word(cmd, row, col, value);
        case (cmd)
            CMD_LOAD_VEC: begin
                vec_loaded[row] = 1'b1;
                loads_sent++;
            end
            CMD_LOAD_MAT: begin
                mat_loaded[row][col] = 1'b1;
                loads_sent++;
            end
            CMD_START: starts_sent++;
            default: ;
        endcase
        if (cmd != CMD_UNUSED)
            words_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (board.expected_sums.size() != 0)
            @(posedge aclk);
        // loads leave no result, give the pipeline time to empty
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic put_register(input logic [REG_W-1:0] idx, input logic [CNT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        board.set_register(idx, data);
        cfg_writes++;
    endtask

    task automatic write_registers(input logic [CNT_W-1:0] vl, input logic [CNT_W-1:0] rc,
                                   input logic [CNT_W-1:0] cc);
        wait_drained();
        put_register(REG_VECTOR_LENGTH, vl);
        if ($urandom_range(0, 3) == 0)
            put_register(REG_UNUSED, CNT_W'($urandom_range(0, 31)));
        put_register(REG_ROW_COUNT, rc);
        put_register(REG_COL_COUNT, cc);
        cfg_valid <= 1'b0;
    endtask

    // a few random words, then if sizes agree each unloaded entry it reads, then start
    task automatic run_product();
        int rows;
        int cols;
        bit sized_ok;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        sized_ok = (board.vector_length == board.row_count) && (board.col_count != 0);
        rows = (board.row_count > DEF_MAX_ROWS) ? DEF_MAX_ROWS : board.row_count;
        cols = (board.col_count > DEF_MAX_COLS) ? DEF_MAX_COLS : board.col_count;
        repeat ($urandom_range(0, 4)) begin
            r = (rows > 0 && $urandom_range(0, 4) != 0) ? IDX_W'($urandom_range(0, rows - 1))
                                                          : IDX_W'($urandom_range(0, 15));
            c = (cols > 0 && $urandom_range(0, 4) != 0) ? IDX_W'($urandom_range(0, cols - 1))
                                                          : IDX_W'($urandom_range(0, 15));
            case ($urandom_range(0, 9))
                0:       send_word(CMD_UNUSED, IDX_W'($urandom), IDX_W'($urandom),
                                   ELEM_W'($urandom));
                1, 2, 3: send_word(CMD_LOAD_VEC, r, IDX_W'($urandom), pick_value());
                default: send_word(CMD_LOAD_MAT, r, c, pick_value());
            endcase
        end
        if (sized_ok) begin
            for (int i = 0; i < rows; i++)
                if (!vec_loaded[i])
                    send_word(CMD_LOAD_VEC, IDX_W'(i), IDX_W'($urandom), pick_value());
            for (int i = 0; i < rows; i++)
                for (int j = 0; j < cols; j++)
                    if (!mat_loaded[i][j])
                        send_word(CMD_LOAD_MAT, IDX_W'(i), IDX_W'(j), pick_value());
        end
        if ($urandom_range(0, 9) == 0)
            wait_drained();
        send_word(CMD_START, IDX_W'($urandom), IDX_W'($urandom), ELEM_W'($urandom));
    endtask

    initial begin
        int phase;
        int roll;
        logic [CNT_W-1:0] vl;
        logic [CNT_W-1:0] rc;
        logic [CNT_W-1:0] cc;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // reset sizes disagree, so the first start reports a size error
        send_word(CMD_START, 4'hF, 4'hF, 16'shFFFF);
        send_word(CMD_UNUSED, 4'h5, 4'hA, 16'sh1234);

        // no rows: every column sums to zero
        write_registers(5'd0, 5'd0, 5'd3);
        send_word(CMD_START, 4'h0, 4'h0, 16'sh0000);
        // no columns
        write_registers(5'd0, 5'd0, 5'd0);
        send_word(CMD_START, 4'h0, 4'h0, 16'sh0000);

        write_registers(5'd2, 5'd2, 5'd2);
        send_word(CMD_LOAD_VEC, 4'd0, 4'hF, 16'sh8000);
        send_word(CMD_LOAD_VEC, 4'd1, 4'h0, 16'sh8000);
        send_word(CMD_LOAD_MAT, 4'd0, 4'd0, 16'sh8000);
        send_word(CMD_LOAD_MAT, 4'd1, 4'd0, 16'sh8000);
        send_word(CMD_LOAD_MAT, 4'd0, 4'd1, 16'sh7FFF);
        send_word(CMD_UNUSED, 4'd0, 4'd1, 16'sh0000);
        send_word(CMD_LOAD_MAT, 4'd1, 4'd1, 16'sh7FFF);
        send_word(CMD_START, 4'h0, 4'h0, 16'sh0000);
        send_word(CMD_LOAD_VEC, 4'd1, 4'h0, 16'sh7FFF);
        send_word(CMD_START, 4'hA, 4'h5, 16'sh5555);

        // write to the unused index must leave the sizes alone
        wait_drained();
        put_register(REG_UNUSED, 5'h1F);
        cfg_valid <= 1'b0;
        send_word(CMD_START, 4'h5, 4'hA, 16'shAAAA);

        write_registers(5'd3, 5'd2, 5'd2);
        send_word(CMD_START, 4'h0, 4'h0, 16'sh0000);
        send_word(CMD_LOAD_VEC, 4'd15, 4'hF, 16'sh7FFF);
        send_word(CMD_LOAD_MAT, 4'd15, 4'd15, 16'sh8000);

        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            case (phase)
                0: begin vl = 5'd31; rc = 5'd31; cc = 5'd1;  end
                1: begin vl = 5'd1;  rc = 5'd1;  cc = 5'd31; end
                2: begin vl = 5'd16; rc = 5'd16; cc = 5'd2;  end
                3: begin vl = 5'd2;  rc = 5'd2;  cc = 5'd16; end
                // both give the same row count once capped but the raw values differ
                4: begin vl = 5'd16; rc = 5'd31; cc = 5'd1;  end
                default: begin
                    roll = $urandom_range(0, 99);
                    rc = CNT_W'($urandom_range(1, 4));
                    vl = rc;
                    cc = CNT_W'($urandom_range(1, 4));
                    if (roll >= 60 && roll < 72) begin
                        vl = CNT_W'($urandom_range(0, 31));
                    end else if (roll >= 72 && roll < 80) begin
                        vl = 5'd0;
                        rc = 5'd0;
                        cc = CNT_W'($urandom_range(0, 16));
                    end else if (roll >= 80 && roll < 86) begin
                        cc = 5'd0;
                    end else if (roll >= 86 && roll < 93) begin
                        rc = CNT_W'($urandom_range(5, 31));
                        vl = rc;
                        cc = CNT_W'($urandom_range(1, 2));
                    end else if (roll >= 93) begin
                        rc = CNT_W'($urandom_range(1, 2));
                        vl = rc;
                        cc = CNT_W'($urandom_range(5, 31));
                    end
                end
            endcase
            calm = ($urandom_range(0, 4) == 0);
            write_registers(vl, rc, cc);
            repeat ($urandom_range(2, 6)) run_product();
            phase++;
        end

        wait_drained();
        $display("%0d loads, %0d starts, %0d register writes over %0d size settings",
                 loads_sent, starts_sent, cfg_writes, phase + 5);
        $display("%0d result words checked, %0d of them size errors, %0d mismatches",
                 board.results_seen, board.error_results, board.mismatches);
        if (board.mismatches == 0)
            $display("[vector_matrix_multiply_top] OK");
        else
            $display("[vector_matrix_multiply_top] ERROR");
        $finish;
    end

endmodule
